### design/spsa_pkg.sv
// Shared types and constants for the slab page slot allocator.
// No dependencies; every other design file imports this package.
package spsa_pkg;

  // Fixed field widths of the request and result transactions
  localparam int REQ_W   = 2;
  localparam int OFF_W   = 12;
  localparam int STAT_W  = 3;
  localparam int USED_W  = 8;
  localparam int CLASS_W = 3;

  // Largest legal size class (1024-byte slots); higher codes saturate
  localparam logic [CLASS_W-1:0] CLASS_MAX = 3'd6;

  // Slot size is 1 << (class + SLOT_SHIFT_BASE)
  localparam logic [3:0] SLOT_SHIFT_BASE = 4'd4;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_INIT  = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_RANGE  = 3'd2,
    ST_ALIGN  = 3'd3,
    ST_DOUBLE = 3'd4
  } status_t;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  // Outcome of the offset checks on a free request
  typedef struct packed {
    logic    reject;
    status_t status;
  } chk_t;

endpackage

### design/spsa_in_if.sv
// Request channel of the slab page slot allocator: valid/ready plus payload.
// Depends on spsa_pkg for the field widths.
interface spsa_in_if import spsa_pkg::*;;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [OFF_W-1:0] free_offset;

  modport source (output valid, req_type, free_offset, input ready);
  modport sink   (input valid, req_type, free_offset, output ready);
endinterface

### design/spsa_out_if.sv
// Result channel of the slab page slot allocator: valid/ready plus payload.
// Depends on spsa_pkg for the field widths.
interface spsa_out_if import spsa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [OFF_W-1:0]  slot_offset;
  logic [USED_W-1:0] used_slots;
  logic              page_empty;

  modport source (output valid, status, slot_offset, used_slots, page_empty, input ready);
  modport sink   (input valid, status, slot_offset, used_slots, page_empty, output ready);
endinterface

### design/spsa_free_check.sv
// Offset checks for a free request: range, tail slack, alignment, slot index.
// Depends on spsa_pkg (chk_t, status codes, field widths).
module spsa_free_check import spsa_pkg::*; #(
  parameter int PAGE_BYTES   = 4096,
  parameter int HEADER_BYTES = 48,
  parameter int MAX_SLOTS    = 256,
  parameter int CW           = 14,
  parameter int IW           = 8
) (
  input  logic [OFF_W-1:0] free_offset,
  input  logic [3:0]       slot_shift,
  input  logic [CW-1:0]    page_end,
  output chk_t             chk,
  output logic [IW-1:0]    slot
);

  logic [CW-1:0] off_w;
  logic [CW-1:0] rel;
  logic [CW-1:0] mask;
  logic [CW-1:0] slot_w;

  // Offset relative to the first slot, then split into index and remainder
  assign off_w  = CW'(free_offset);
  assign rel    = off_w - CW'(HEADER_BYTES);
  assign mask   = (CW'(1) << slot_shift) - CW'(1);
  assign slot_w = rel >> slot_shift;
  assign slot   = slot_w[IW-1:0];

  always_comb begin
    chk.reject = 1'b1;
    chk.status = ST_RANGE;
    if (off_w < CW'(HEADER_BYTES) || off_w >= CW'(PAGE_BYTES) || off_w >= page_end) begin
      chk.status = ST_RANGE;
    end else if ((rel & mask) != '0) begin
      chk.status = ST_ALIGN;
    end else if (slot_w >= CW'(MAX_SLOTS)) begin
      chk.status = ST_RANGE;
    end else begin
      chk.reject = 1'b0;
      chk.status = ST_OK;
    end
  end

endmodule

### design/slab_page_slot_allocator.sv
// Slab page slot allocator: LIFO free list of one page kept in a slot memory.
// The result is registered when the execute state completes; an unread result holds it there.
// A new request is taken only once the current one is done (slot memory read, then write-back).
// Reset and init clear head, count and high-water mark; slots at or
// above the mark read as free and chained to the next, so no clearing pass runs.
// Depends on spsa_pkg, spsa_in_if, spsa_out_if and spsa_free_check.
module slab_page_slot_allocator import spsa_pkg::*; #(
  parameter int PAGE_BYTES   = 4096,
  parameter int HEADER_BYTES = 48,
  parameter int MAX_SLOTS    = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  spsa_in_if.sink            in_chan,
  spsa_out_if.source         out_chan,
  input  logic               cfg_wr_en,
  input  logic [CLASS_W-1:0] cfg_wr_data
);

  localparam int IW     = $clog2(MAX_SLOTS);
  localparam int CNTW   = $clog2(MAX_SLOTS + 1);
  localparam int CW_RAW = $clog2(PAGE_BYTES + HEADER_BYTES + 1) + 1;
  localparam int CW     = (CW_RAW > 13) ? CW_RAW : 13;
  localparam int AVAIL  = PAGE_BYTES - HEADER_BYTES;

  // Control state
  state_t             state_r;
  logic [CLASS_W-1:0] class_r;
  logic [IW-1:0]      head_r,  head_nxt;
  logic [CNTW-1:0]    count_r, count_nxt;
  logic [CNTW-1:0]    mark_r,  mark_nxt;
  logic               out_valid_r;

  // Request held for the execute cycle
  req_t               op_r;
  chk_t               pre_r;
  logic [IW-1:0]      slot_r;

  // Result register
  status_t            out_status_r, status_nxt;
  logic [OFF_W-1:0]   out_off_r,    off_nxt;
  logic [USED_W-1:0]  out_used_r;
  logic               out_empty_r;

  // Slot memory: {free bit, next link}
  logic [IW:0]        slot_mem [MAX_SLOTS];
  logic [IW:0]        rd_q;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [IW:0]        wr_data;

  logic               accept;
  logic               done;
  logic [3:0]         slot_shift;
  logic [CW-1:0]      total_w;
  logic [CNTW-1:0]    n_slots;
  logic [CW-1:0]      page_end;
  chk_t               chk;
  logic [IW-1:0]      chk_slot;
  logic               head_stored;
  logic               slot_stored;
  logic [CNTW-1:0]    head_inc;
  logic [IW-1:0]      fresh_link;
  logic [IW-1:0]      pop_link;
  logic               slot_free;
  logic [CW-1:0]      pop_off;

  // Geometry of the page for the current size class
  assign slot_shift = 4'(class_r) + SLOT_SHIFT_BASE;
  assign total_w    = CW'(AVAIL) >> slot_shift;
  assign n_slots    = (total_w > CW'(MAX_SLOTS)) ? CNTW'(MAX_SLOTS) : total_w[CNTW-1:0];
  assign page_end   = CW'(HEADER_BYTES) + (CW'(n_slots) << slot_shift);

  spsa_free_check #(
    .PAGE_BYTES  (PAGE_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_SLOTS   (MAX_SLOTS),
    .CW          (CW),
    .IW          (IW)
  ) u_free_check (
    .free_offset(in_chan.free_offset),
    .slot_shift (slot_shift),
    .page_end   (page_end),
    .chk        (chk),
    .slot       (chk_slot)
  );

  // Handshakes
  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && (state_r == S_IDLE);
  assign done          = (state_r == S_EXEC) && (!out_valid_r || out_chan.ready);

  // Read the list head for an alloc, the target slot for a free
  assign rd_addr = (req_t'(in_chan.req_type) == REQ_FREE) ? chk_slot : head_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q <= slot_mem[rd_addr];
    end
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
  end

  // Slots below the high-water mark live in memory; at or above it they are fresh
  assign head_stored = (CNTW'(head_r) < mark_r);
  assign slot_stored = (CNTW'(slot_r) < mark_r);
  assign head_inc    = CNTW'(head_r) + CNTW'(1);
  assign fresh_link  = (head_inc < n_slots) ? head_inc[IW-1:0] : '0;
  assign pop_link    = head_stored ? rd_q[IW-1:0] : fresh_link;
  assign slot_free   = slot_stored ? rd_q[IW] : 1'b1;
  assign pop_off     = CW'(HEADER_BYTES) + (CW'(head_r) << slot_shift);

  // Execute: modify the list and write the touched entry back
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    mark_nxt   = mark_r;
    status_nxt = ST_OK;
    off_nxt    = '0;
    wr_en      = 1'b0;
    wr_addr    = head_r;
    wr_data    = {1'b0, pop_link};
    case (op_r)
      REQ_ALLOC: begin
        if (count_r >= n_slots) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = done;
          head_nxt  = pop_link;
          count_nxt = count_r + CNTW'(1);
          if (!head_stored) begin
            mark_nxt = mark_r + CNTW'(1);
          end
          off_nxt = pop_off[OFF_W-1:0];
        end
      end
      REQ_FREE: begin
        if (pre_r.reject) begin
          status_nxt = pre_r.status;
        end else if (slot_free) begin
          status_nxt = ST_DOUBLE;
        end else begin
          wr_en    = done;
          wr_addr  = slot_r;
          wr_data  = {1'b1, head_r};
          head_nxt = slot_r;
          if (count_r != '0) begin
            count_nxt = count_r - CNTW'(1);
          end
        end
      end
      REQ_INIT: begin
        head_nxt  = '0;
        count_nxt = '0;
        mark_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      class_r     <= '0;
      head_r      <= '0;
      count_r     <= '0;
      mark_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A new result replaces the one taken in the same cycle
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (done) begin
            state_r <= S_IDLE;
            head_r  <= head_nxt;
            count_r <= count_nxt;
            mark_r  <= mark_nxt;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      // Class write rebuilds the page
      if (cfg_wr_en) begin
        class_r <= (cfg_wr_data > CLASS_MAX) ? CLASS_MAX : cfg_wr_data;
        head_r  <= '0;
        count_r <= '0;
        mark_r  <= '0;
      end
    end
  end

  // Request capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= req_t'(in_chan.req_type);
      pre_r  <= chk;
      slot_r <= chk_slot;
    end
    if (done) begin
      out_status_r <= status_nxt;
      out_off_r    <= off_nxt;
      out_used_r   <= USED_W'(count_nxt);
      out_empty_r  <= (count_nxt == '0);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.slot_offset = out_off_r;
  assign out_chan.used_slots  = out_used_r;
  assign out_chan.page_empty  = out_empty_r;

endmodule
